// ===== design/omrc_pkg.sv =====
// shared constants, command and status types for the miss counter
package omrc_pkg;

    localparam int MAX_SLOTS_DEF    = 16;
    localparam int MAX_REQUESTS_DEF = 128;
    localparam int ID_BITS_DEF      = 8;

    localparam int DEV_ID_W     = 8;
    localparam int EVC_W        = 8;
    localparam int SLOT_COUNT_W = 5;
    localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 5'd16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    // word index of the slot count register (paddr[2])
    localparam logic REG_SLOT_COUNT = 1'b0;

    typedef struct packed {
        logic load;
        logic look;
        logic fill;
        logic next;
        logic rd_scan;
        logic scan_cmp;
        logic evict;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic item_last;
        logic i_at_end;
        logic id_skip;
        logic has_empty;
        logic one_left_init;
        logic l_at_end;
        logic one_left;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/omrc_ifs.sv =====
// request and result stream interfaces
interface omrc_req_if;
    import omrc_pkg::*;
    logic                valid;
    logic                ready;
    logic [DEV_ID_W-1:0] device_id;
    logic                last;
    modport source (output valid, device_id, last, input ready);
    modport sink   (input valid, device_id, last, output ready);
endinterface

interface omrc_res_if;
    import omrc_pkg::*;
    logic             valid;
    logic             ready;
    logic [EVC_W-1:0] eviction_count;
    logic             overflow;
    modport source (output valid, eviction_count, overflow, input ready);
    modport sink   (input valid, eviction_count, overflow, output ready);
endinterface

// ===== design/omrc_ram.sv =====
// generic single write, single read ram with registered read data
module omrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/omrc_ctrl.sv =====
// sequencer for load, replay, look-ahead scan and result hand-off
module omrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output omrc_pkg::t_dp_cmd o_cmd,
    input  omrc_pkg::t_dp_sts i_sts
);
    import omrc_pkg::*;

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_FETCH    = 3'd1;
    localparam logic [2:0] ST_LOOK     = 3'd2;
    localparam logic [2:0] ST_SCAN_RD  = 3'd3;
    localparam logic [2:0] ST_SCAN_CMP = 3'd4;
    localparam logic [2:0] ST_EVICT    = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                // no request is taken while reset is held
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.item_last) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // store read of the current position is issued here
                n_state = i_sts.i_at_end ? ST_DONE : ST_LOOK;
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                if (i_sts.id_skip) begin
                    o_cmd.next = 1'b1;
                    n_state    = ST_FETCH;
                end else if (i_sts.has_empty) begin
                    o_cmd.fill = 1'b1;
                    o_cmd.next = 1'b1;
                    n_state    = ST_FETCH;
                end else if (i_sts.one_left_init) begin
                    n_state = ST_EVICT;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (i_sts.l_at_end) begin
                    n_state = ST_EVICT;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_sts.one_left ? ST_EVICT : ST_SCAN_RD;
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_FETCH;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== design/omrc_dp.sv =====
// request store, slot table, look-ahead tracking and result register
module omrc_dp #(
    parameter int MAX_SLOTS    = omrc_pkg::MAX_SLOTS_DEF,
    parameter int MAX_REQUESTS = omrc_pkg::MAX_REQUESTS_DEF,
    parameter int ID_BITS      = omrc_pkg::ID_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  omrc_pkg::t_dp_cmd                   i_cmd,
    output omrc_pkg::t_dp_sts                   o_sts,
    input  logic [omrc_pkg::DEV_ID_W-1:0]       i_device_id,
    input  logic                                i_last,
    input  logic [omrc_pkg::SLOT_COUNT_W-1:0]   i_slot_count,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [omrc_pkg::EVC_W-1:0]          o_eviction_count,
    output logic                                o_overflow
);
    import omrc_pkg::*;

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int AW = $clog2(MAX_REQUESTS);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [CW-1:0]      r_cnt;
    logic               r_ovf_seen;
    logic [CW-1:0]      r_total;
    logic               r_ovf_run;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_l;
    logic [ID_BITS-1:0] r_slot [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_act;
    logic [MAX_SLOTS-1:0] r_found;
    logic [ID_BITS-1:0] r_cur_id;
    logic [EVC_W-1:0]   r_evc;
    logic               r_out_valid;
    logic [EVC_W-1:0]   r_out_evc;
    logic               r_out_ovf;

    logic [ID_BITS-1:0]   w_in_id;
    logic [ID_BITS-1:0]   w_rd_id;
    logic                 w_has_room;
    logic [CW-1:0]        w_cnt_inc;
    logic [MAX_SLOTS-1:0] w_match;
    logic [MAX_SLOTS-1:0] w_empty;
    logic [MAX_SLOTS-1:0] w_found_nx;
    logic [MAX_SLOTS-1:0] w_unf_nx;
    logic [MAX_SLOTS-1:0] w_unf_init;
    logic [SW-1:0]        w_empty_idx;
    logic [SW-1:0]        w_victim;
    logic [AW-1:0]        w_raddr;

    assign w_in_id    = ID_BITS'(i_device_id);
    assign w_has_room = (r_cnt < CW'(MAX_REQUESTS));
    assign w_cnt_inc  = w_has_room ? r_cnt + CW'(1) : r_cnt;
    assign w_raddr    = i_cmd.rd_scan ? r_l[AW-1:0] : r_i[AW-1:0];

    omrc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_has_room),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_in_id),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_id)
    );

    always_comb begin
        for (int j = 0; j < MAX_SLOTS; j++) begin
            w_match[j] = r_act[j] && (r_slot[j] == w_rd_id);
            w_empty[j] = r_act[j] && (r_slot[j] == '0);
        end
    end

    assign w_found_nx = r_found | w_match;
    assign w_unf_nx   = ~w_found_nx;
    assign w_unf_init = ~(~r_act);

    // lowest set bit pickers
    always_comb begin
        w_empty_idx = '0;
        w_victim    = '0;
        for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
            if (w_empty[j]) begin
                w_empty_idx = SW'(j);
            end
            if (!r_found[j]) begin
                w_victim = SW'(j);
            end
        end
    end

    always_comb begin
        o_sts               = '0;
        o_sts.item_last     = i_last;
        o_sts.i_at_end      = (r_i == r_total);
        o_sts.id_skip       = (w_rd_id == '0) || (|w_match);
        o_sts.has_empty     = |w_empty;
        o_sts.one_left_init = (w_unf_init != '0) &&
                              ((w_unf_init & (w_unf_init - MAX_SLOTS'(1))) == '0);
        o_sts.l_at_end      = (r_l == r_total);
        o_sts.one_left      = (w_unf_nx != '0) &&
                              ((w_unf_nx & (w_unf_nx - MAX_SLOTS'(1))) == '0);
        o_sts.out_free      = !r_out_valid || i_res_ready;
    end

    // load side and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_last) begin
                    r_cnt      <= '0;
                    r_ovf_seen <= 1'b0;
                end else begin
                    r_cnt      <= w_cnt_inc;
                    r_ovf_seen <= r_ovf_seen || !w_has_room;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // replay datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_last) begin
            r_total   <= w_cnt_inc;
            r_ovf_run <= r_ovf_seen || !w_has_room;
            r_i       <= '0;
            r_evc     <= '0;
            for (int j = 0; j < MAX_SLOTS; j++) begin
                r_slot[j] <= '0;
                r_act[j]  <= (j == 0) || (j < int'(i_slot_count));
            end
        end
        if (i_cmd.look) begin
            r_cur_id <= w_rd_id;
            r_found  <= ~r_act;
            r_l      <= r_i + CW'(1);
        end
        if (i_cmd.fill) begin
            r_slot[w_empty_idx] <= w_rd_id;
        end
        if (i_cmd.scan_cmp) begin
            r_found <= w_found_nx;
            r_l     <= r_l + CW'(1);
        end
        if (i_cmd.evict) begin
            r_slot[w_victim] <= r_cur_id;
            if (r_evc != '1) begin
                r_evc <= r_evc + EVC_W'(1);
            end
        end
        if (i_cmd.next || i_cmd.evict) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.emit) begin
            r_out_evc <= r_evc;
            r_out_ovf <= r_ovf_run;
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_eviction_count = r_out_evc;
    assign o_overflow       = r_out_ovf;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_REQUESTS))
        else $error("request count past store depth");

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |-> ((~r_found) != '0))
        else $error("eviction with every slot marked as used ahead");

    a_fill_has_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (|w_empty))
        else $error("fill without an empty slot");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_scan |-> (r_l > r_i) && (r_l < r_total))
        else $error("look-ahead read outside the sequence");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_res_ready))
        else $error("result overwritten before taken");
endmodule

// ===== design/optimal_replacement_miss_counter_unit.sv =====
// top level: belady replacement miss counter with apb slot count register
//
// channel  | dir | payload                     | handshake
// i_req    | in  | device_id[7:0], last        | valid/ready
// o_res    | out | eviction_count[7:0], overflow | valid/ready
// apb      | in  | slot_count at byte addr 0   | psel/penable, pready tied high
//
// the block is ready every cycle while loading
// replay does a store read and a slot compare per stored request; a miss with all slots
// full adds a look-ahead read and compare per request scanned, a step if the scan hits the
// end, and an eviction; after the last request the end is detected, then the result is
// queued when the output register frees; input is stalled from the last request till then
// reset is synchronous and clears counters, flags, state and the output valid
module optimal_replacement_miss_counter_unit #(
    parameter int MAX_SLOTS    = omrc_pkg::MAX_SLOTS_DEF,
    parameter int MAX_REQUESTS = omrc_pkg::MAX_REQUESTS_DEF,
    parameter int ID_BITS      = omrc_pkg::ID_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [omrc_pkg::APB_AW-1:0]   paddr,
    input  logic [omrc_pkg::APB_DW-1:0]   pwdata,
    output logic [omrc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // request and result streams
    omrc_req_if.sink                      i_req,
    omrc_res_if.source                    o_res
);
    import omrc_pkg::*;

    logic [SLOT_COUNT_W-1:0] r_slot_count;
    logic                    w_wr_slot_count;
    t_dp_cmd                 w_cmd;
    t_dp_sts                 w_sts;

    // register write completes in the access phase; pready is always high
    assign pready          = 1'b1;
    assign w_wr_slot_count = psel && penable && pwrite &&
                             (paddr[APB_AW-1] == REG_SLOT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RST;
        end else if (w_wr_slot_count) begin
            r_slot_count <= pwdata[SLOT_COUNT_W-1:0];
        end
    end

    // read back; unused word reads as zero
    assign prdata = (paddr[APB_AW-1] == REG_SLOT_COUNT) ?
                    APB_DW'(r_slot_count) : '0;

    // sequencer: accepts requests only in its load state
    omrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // store, slot table, look-ahead marks, eviction counter, result register
    omrc_dp #(
        .MAX_SLOTS    (MAX_SLOTS),
        .MAX_REQUESTS (MAX_REQUESTS),
        .ID_BITS      (ID_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_device_id      (i_req.device_id),
        .i_last           (i_req.last),
        .i_slot_count     (r_slot_count),
        .o_res_valid      (o_res.valid),
        .i_res_ready      (o_res.ready),
        .o_eviction_count (o_res.eviction_count),
        .o_overflow       (o_res.overflow)
    );
endmodule
